### rtl/awbd_pkg.sv
// ----------------------------------------------------------------------------
// awbd_pkg: shared types and constants for the alpha weighted box downscaler
// Word layouts, register indexes, controller states and default sizes.
// ----------------------------------------------------------------------------
package awbd_pkg;

    localparam int AWBD_MAX_WIDTH = 4096;
    localparam int AWBD_FRAC_BITS = 8;
    localparam int AWBD_IDX_W     = 2;
    localparam int AWBD_CFG_W     = 16;
    localparam int AWBD_SUM_W     = 24;
    localparam int AWBD_ASUM_W    = 16;

    localparam logic [AWBD_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
    localparam logic [AWBD_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
    localparam logic [AWBD_IDX_W-1:0] REG_ROW_RATIO  = 2'd2;
    localparam logic [AWBD_IDX_W-1:0] REG_COL_RATIO  = 2'd3;

    localparam logic [12:0] RST_SRC_WIDTH  = 13'd64;
    localparam logic [15:0] RST_SRC_HEIGHT = 16'd64;
    localparam logic [11:0] RST_ROW_RATIO  = 12'd512;
    localparam logic [11:0] RST_COL_RATIO  = 12'd256;

    typedef struct packed {
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
        logic [7:0] in_alpha;
    } t_pix_in;

    typedef struct packed {
        logic [7:0]  out_red;
        logic [7:0]  out_green;
        logic [7:0]  out_blue;
        logic [7:0]  out_alpha;
        logic [15:0] out_row;
        logic [11:0] out_column;
        logic        frame_end;
    } t_pix_out;

    typedef struct packed {
        logic [AWBD_SUM_W-1:0]  red_sum;
        logic [AWBD_SUM_W-1:0]  green_sum;
        logic [AWBD_SUM_W-1:0]  blue_sum;
        logic [AWBD_ASUM_W-1:0] alpha_sum;
        logic [7:0]             alpha_peak;
    } t_acc;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ACC,
        S_DIV,
        S_OUT
    } t_state;

endpackage

### rtl/alpha_weighted_box_downscaler.sv
// ----------------------------------------------------------------------------
// alpha_weighted_box_downscaler
// Premultiplied-alpha box filter that shrinks an RGBA raster by Q ratios.
// ----------------------------------------------------------------------------
// Words are processed one at a time; the input stalls until the last word is
// done. A pixel outside every output block only advances the counters, a pixel
// that only accumulates reads its column memory entry and writes it back, and a
// pixel that closes a block also runs the divide and waits for the output
// handshake: the three color quotients share one divisor in a radix-2 divider
// that resolves one of the 24 quotient bits per cycle. Column sums live in one
// memory of MAX_WIDTH entries; no clearing pass is needed after reset.
module alpha_weighted_box_downscaler #(
    parameter int MAX_WIDTH       = awbd_pkg::AWBD_MAX_WIDTH,
    parameter int RATIO_FRAC_BITS = awbd_pkg::AWBD_FRAC_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [awbd_pkg::AWBD_IDX_W-1:0] i_cfg_idx,
    input  logic [awbd_pkg::AWBD_CFG_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    input  awbd_pkg::t_pix_in               i_in_data,
    output logic                            o_in_stall,
    output logic                            o_out_valid,
    output awbd_pkg::t_pix_out              o_out_data,
    input  logic                            i_out_stall
);
    import awbd_pkg::*;

    localparam int F    = RATIO_FRAC_BITS;
    localparam int AW   = $clog2(MAX_WIDTH);
    localparam int WW   = AW + 1;
    localparam int CB_W = (AW + F + 2 > 14) ? AW + F + 2 : 14;
    localparam int RB_W = F + 18;
    localparam logic [CB_W-1:0] ONE_C = CB_W'(1) << F;
    localparam logic [RB_W-1:0] ONE_R = RB_W'(1) << F;
    localparam logic [4:0] DIV_LAST = 5'(AWBD_SUM_W - 1);

    // configuration and frame counters
    logic [12:0]     r_sw, n_sw;
    logic [15:0]     r_sh, n_sh;
    logic [11:0]     r_rr, n_rr;
    logic [11:0]     r_cr, n_cr;
    logic [AW-1:0]   r_c, n_c;
    logic [15:0]     r_r, n_r;
    logic [11:0]     r_oc, n_oc;
    logic [15:0]     r_or, n_or;
    logic [CB_W-1:0] r_cb, n_cb;
    logic [RB_W-1:0] r_rb, n_rb;
    t_state          r_state, n_state;

    // per-word job
    logic            r_first, n_first;
    logic            r_emit, n_emit;
    logic            r_fe, n_fe;
    logic [15:0]     r_orow, n_orow;
    logic [11:0]     r_ocol, n_ocol;
    logic [AW-1:0]   r_addr, n_addr;
    logic [15:0]     r_pr, n_pr, r_pg, n_pg, r_pb, n_pb;
    logic [7:0]      r_a, n_a;

    // divider
    logic [AWBD_SUM_W-1:0]  r_qr, n_qr, r_qg, n_qg, r_qb, n_qb;
    logic [AWBD_ASUM_W-1:0] r_mr, n_mr, r_mg, n_mg, r_mb, n_mb;
    logic [AWBD_ASUM_W-1:0] r_dv, n_dv;
    logic [4:0]             r_cnt, n_cnt;
    logic                   r_ok, n_ok;
    logic [7:0]             r_pk, n_pk;
    t_pix_out               r_out, n_out;

    // column memory
    t_acc            mem [MAX_WIDTH];
    t_acc            r_rdata;
    t_acc            acc;
    logic            mem_re;
    logic            mem_we;

    logic [WW-1:0]   w_eff;
    logic [15:0]     h_eff;
    logic [CB_W-1:0] cr_e, cr_ne, w_fix;
    logic [RB_W-1:0] rr_e, rr_ne, h_fix;
    logic            col_valid, row_valid, col_last, row_last;
    logic            col_first, row_first, j_ok, active, accept;
    logic [AWBD_ASUM_W:0] tr, tg, tb;
    logic            br, bg, bb;

    always_comb begin
        if (r_sw == 13'd0) begin
            w_eff = WW'(1);
        end else if (32'(r_sw) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_sw);
        end
        h_eff = (r_sh == 16'd0) ? 16'd1 : r_sh;
        cr_e  = (CB_W'(r_cr) < ONE_C) ? ONE_C : CB_W'(r_cr);
        rr_e  = (RB_W'(r_rr) < ONE_R) ? ONE_R : RB_W'(r_rr);
        cr_ne = (CB_W'(n_cr) < ONE_C) ? ONE_C : CB_W'(n_cr);
        rr_ne = (RB_W'(n_rr) < ONE_R) ? ONE_R : RB_W'(n_rr);
        w_fix = CB_W'(w_eff) << F;
        h_fix = RB_W'(h_eff) << F;
    end

    assign col_valid = r_cb <= w_fix;
    assign row_valid = r_rb <= h_fix;
    assign col_last  = (CB_W'(r_c) + CB_W'(1)) == (r_cb >> F);
    assign row_last  = (RB_W'(r_r) + RB_W'(1)) == (r_rb >> F);
    assign col_first = CB_W'(r_c) == ((r_cb - cr_e) >> F);
    assign row_first = RB_W'(r_r) == ((r_rb - rr_e) >> F);
    assign j_ok      = 32'(r_oc) < MAX_WIDTH;
    assign active    = col_valid && row_valid && j_ok;
    assign accept    = i_in_valid && (r_state == S_IDLE);
    assign mem_re    = accept && active;
    assign mem_we    = r_state == S_ACC;

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_state == S_OUT;
    assign o_out_data  = r_out;

    always_comb begin
        if (r_first) begin
            acc.red_sum   = AWBD_SUM_W'(r_pr);
            acc.green_sum = AWBD_SUM_W'(r_pg);
            acc.blue_sum  = AWBD_SUM_W'(r_pb);
            acc.alpha_sum = AWBD_ASUM_W'(r_a);
            acc.alpha_peak = r_a;
        end else begin
            acc.red_sum   = r_rdata.red_sum + AWBD_SUM_W'(r_pr);
            acc.green_sum = r_rdata.green_sum + AWBD_SUM_W'(r_pg);
            acc.blue_sum  = r_rdata.blue_sum + AWBD_SUM_W'(r_pb);
            acc.alpha_sum = r_rdata.alpha_sum + AWBD_ASUM_W'(r_a);
            acc.alpha_peak = (r_a > r_rdata.alpha_peak) ? r_a : r_rdata.alpha_peak;
        end
    end

    // restoring divide step, three channels over one divisor
    always_comb begin
        tr = {r_mr, r_qr[AWBD_SUM_W-1]};
        tg = {r_mg, r_qg[AWBD_SUM_W-1]};
        tb = {r_mb, r_qb[AWBD_SUM_W-1]};
        br = tr >= {1'b0, r_dv};
        bg = tg >= {1'b0, r_dv};
        bb = tb >= {1'b0, r_dv};
    end

    always_comb begin
        n_sw = r_sw; n_sh = r_sh; n_rr = r_rr; n_cr = r_cr;
        n_c = r_c; n_r = r_r; n_oc = r_oc; n_or = r_or;
        n_cb = r_cb; n_rb = r_rb; n_state = r_state;
        n_first = r_first; n_emit = r_emit; n_fe = r_fe;
        n_orow = r_orow; n_ocol = r_ocol; n_addr = r_addr;
        n_pr = r_pr; n_pg = r_pg; n_pb = r_pb; n_a = r_a;
        n_qr = r_qr; n_qg = r_qg; n_qb = r_qb;
        n_mr = r_mr; n_mg = r_mg; n_mb = r_mb;
        n_dv = r_dv; n_cnt = r_cnt; n_ok = r_ok; n_pk = r_pk; n_out = r_out;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_first = row_first && col_first;
                    n_emit  = col_last && row_last;
                    n_fe    = ((r_rb + rr_e) > h_fix) && ((r_cb + cr_e) > w_fix);
                    n_orow  = r_or;
                    n_ocol  = r_oc;
                    n_addr  = AW'(r_oc);
                    n_a     = i_in_data.in_alpha;
                    n_pr    = 16'(i_in_data.in_alpha) * 16'(i_in_data.in_red);
                    n_pg    = 16'(i_in_data.in_alpha) * 16'(i_in_data.in_green);
                    n_pb    = 16'(i_in_data.in_alpha) * 16'(i_in_data.in_blue);
                    if (active) begin
                        n_state = S_ACC;
                    end
                    if (col_valid && col_last) begin
                        n_oc = r_oc + 12'd1;
                        n_cb = r_cb + cr_e;
                    end
                    if ((WW'(r_c) + WW'(1)) >= w_eff) begin
                        n_c  = '0;
                        n_oc = '0;
                        n_cb = cr_e;
                        if (row_valid && row_last) begin
                            n_or = r_or + 16'd1;
                            n_rb = r_rb + rr_e;
                        end
                        if ((17'(r_r) + 17'd1) >= 17'(h_eff)) begin
                            n_r  = '0;
                            n_or = '0;
                            n_rb = rr_e;
                        end else begin
                            n_r = r_r + 16'd1;
                        end
                    end else begin
                        n_c = r_c + AW'(1);
                    end
                end
            end
            S_ACC: begin
                if (r_emit) begin
                    n_qr  = acc.red_sum;
                    n_qg  = acc.green_sum;
                    n_qb  = acc.blue_sum;
                    n_mr  = '0;
                    n_mg  = '0;
                    n_mb  = '0;
                    n_dv  = acc.alpha_sum;
                    n_pk  = acc.alpha_peak;
                    n_ok  = (acc.alpha_peak != 8'd0) && (acc.alpha_sum != '0);
                    n_cnt = '0;
                    n_state = S_DIV;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DIV: begin
                n_qr = {r_qr[AWBD_SUM_W-2:0], br};
                n_qg = {r_qg[AWBD_SUM_W-2:0], bg};
                n_qb = {r_qb[AWBD_SUM_W-2:0], bb};
                n_mr = br ? AWBD_ASUM_W'(tr - {1'b0, r_dv}) : AWBD_ASUM_W'(tr);
                n_mg = bg ? AWBD_ASUM_W'(tg - {1'b0, r_dv}) : AWBD_ASUM_W'(tg);
                n_mb = bb ? AWBD_ASUM_W'(tb - {1'b0, r_dv}) : AWBD_ASUM_W'(tb);
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == DIV_LAST) begin
                    n_out.out_red    = r_ok ? n_qr[7:0] : 8'd0;
                    n_out.out_green  = r_ok ? n_qg[7:0] : 8'd0;
                    n_out.out_blue   = r_ok ? n_qb[7:0] : 8'd0;
                    n_out.out_alpha  = r_pk;
                    n_out.out_row    = r_orow;
                    n_out.out_column = r_ocol;
                    n_out.frame_end  = r_fe;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SRC_WIDTH:  n_sw = i_cfg_data[12:0];
                REG_SRC_HEIGHT: n_sh = i_cfg_data[15:0];
                REG_ROW_RATIO:  n_rr = i_cfg_data[11:0];
                REG_COL_RATIO:  n_cr = i_cfg_data[11:0];
                default:        n_sw = r_sw;
            endcase
            n_c  = '0;
            n_r  = '0;
            n_oc = '0;
            n_or = '0;
            n_cb = cr_ne;
            n_rb = rr_ne;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw    <= RST_SRC_WIDTH;
            r_sh    <= RST_SRC_HEIGHT;
            r_rr    <= RST_ROW_RATIO;
            r_cr    <= RST_COL_RATIO;
            r_c     <= '0;
            r_r     <= '0;
            r_oc    <= '0;
            r_or    <= '0;
            r_cb    <= (CB_W'(RST_COL_RATIO) < ONE_C) ? ONE_C : CB_W'(RST_COL_RATIO);
            r_rb    <= (RB_W'(RST_ROW_RATIO) < ONE_R) ? ONE_R : RB_W'(RST_ROW_RATIO);
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_sw    <= n_sw;
            r_sh    <= n_sh;
            r_rr    <= n_rr;
            r_cr    <= n_cr;
            r_c     <= n_c;
            r_r     <= n_r;
            r_oc    <= n_oc;
            r_or    <= n_or;
            r_cb    <= n_cb;
            r_rb    <= n_rb;
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_first <= n_first;
        r_emit  <= n_emit;
        r_fe    <= n_fe;
        r_orow  <= n_orow;
        r_ocol  <= n_ocol;
        r_addr  <= n_addr;
        r_pr    <= n_pr;
        r_pg    <= n_pg;
        r_pb    <= n_pb;
        r_a     <= n_a;
        r_qr    <= n_qr;
        r_qg    <= n_qg;
        r_qb    <= n_qb;
        r_mr    <= n_mr;
        r_mg    <= n_mg;
        r_mb    <= n_mb;
        r_dv    <= n_dv;
        r_ok    <= n_ok;
        r_pk    <= n_pk;
        r_out   <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rdata <= mem[AW'(r_oc)];
        end
        if (mem_we) begin
            mem[r_addr] <= acc;
        end
    end

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for alpha_weighted_box_downscaler
// Streams RGBA frames under several size and ratio settings, predicts each
// downscaled pixel in a local model and compares every output word by field.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import awbd_pkg::*;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [AWBD_IDX_W-1:0] i_cfg_idx = REG_SRC_WIDTH;
    logic [AWBD_CFG_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    t_pix_in               i_in_data = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    t_pix_out              o_out_data;
    logic                  i_out_stall = 1'b0;

    alpha_weighted_box_downscaler dut (.*);

    always #1 i_clk = ~i_clk;

    // downscale model state
    logic [23:0] red_acc [AWBD_MAX_WIDTH];
    logic [23:0] grn_acc [AWBD_MAX_WIDTH];
    logic [23:0] blu_acc [AWBD_MAX_WIDTH];
    logic [15:0] alf_acc [AWBD_MAX_WIDTH];
    logic [7:0]  alf_peak[AWBD_MAX_WIDTH];
    logic [12:0] src_w;
    logic [15:0] src_h;
    logic [11:0] row_rat, col_rat;
    int unsigned src_row, src_col, dst_row, dst_col;
    longint unsigned row_bnd, col_bnd;

    t_pix_out    expected_pixels[$];
    int          errors = 0;
    int          pixels_sent = 0;
    int          stall_hold = 0;
    bit          quiet = 1'b0;

    function automatic longint unsigned eff_ratio(logic [11:0] r);
        return (r < 12'd256) ? 256 : r;
    endfunction

    function automatic void restart_frame();
        src_row = 0;
        src_col = 0;
        dst_row = 0;
        dst_col = 0;
        row_bnd = eff_ratio(row_rat);
        col_bnd = eff_ratio(col_rat);
    endfunction

    task automatic report(string msg);
        $display("tb: mismatch at %0t: %s", $time, msg);
        errors++;
    endtask

    // advance the model by one source pixel, queue the block result if any
    function automatic void downscale_pixel(t_pix_in p);
        int unsigned     w, h, c, r, j, as, pk;
        longint unsigned rr, cr, wf, hf;
        bit              cv, rv, cl, rl, cf, rf;
        t_pix_out        e;
        w  = (src_w == 0) ? 1 : ((src_w > AWBD_MAX_WIDTH) ? AWBD_MAX_WIDTH : src_w);
        h  = (src_h == 0) ? 1 : src_h;
        rr = eff_ratio(row_rat);
        cr = eff_ratio(col_rat);
        wf = longint'(w) << AWBD_FRAC_BITS;
        hf = longint'(h) << AWBD_FRAC_BITS;
        c  = src_col;
        r  = src_row;
        j  = dst_col;
        cv = col_bnd <= wf;
        rv = row_bnd <= hf;
        cl = (c + 1) == (col_bnd >> AWBD_FRAC_BITS);
        rl = (r + 1) == (row_bnd >> AWBD_FRAC_BITS);
        cf = c == ((col_bnd - cr) >> AWBD_FRAC_BITS);
        rf = r == ((row_bnd - rr) >> AWBD_FRAC_BITS);
        if (cv && rv && j < AWBD_MAX_WIDTH) begin
            if (rf && cf) begin
                red_acc[j]  = p.in_alpha * p.in_red;
                grn_acc[j]  = p.in_alpha * p.in_green;
                blu_acc[j]  = p.in_alpha * p.in_blue;
                alf_acc[j]  = p.in_alpha;
                alf_peak[j] = p.in_alpha;
            end else begin
                red_acc[j] = red_acc[j] + 24'(p.in_alpha * p.in_red);
                grn_acc[j] = grn_acc[j] + 24'(p.in_alpha * p.in_green);
                blu_acc[j] = blu_acc[j] + 24'(p.in_alpha * p.in_blue);
                alf_acc[j] = alf_acc[j] + 16'(p.in_alpha);
                if (p.in_alpha > alf_peak[j]) alf_peak[j] = p.in_alpha;
            end
            if (cl && rl) begin
                as = alf_acc[j];
                pk = alf_peak[j];
                e = '0;
                if (pk != 0 && as != 0) begin
                    e.out_red   = 8'(red_acc[j] / as);
                    e.out_green = 8'(grn_acc[j] / as);
                    e.out_blue  = 8'(blu_acc[j] / as);
                end
                e.out_alpha  = 8'(pk);
                e.out_row    = 16'(dst_row);
                e.out_column = 12'(j);
                e.frame_end  = (row_bnd + rr > hf) && (col_bnd + cr > wf);
                expected_pixels.push_back(e);
            end
        end
        if (cv && cl) begin
            dst_col = (dst_col + 1) & 12'hFFF;
            col_bnd += cr;
        end
        if (c + 1 >= w) begin
            src_col = 0;
            dst_col = 0;
            col_bnd = cr;
            if (rv && rl) begin
                dst_row = (dst_row + 1) & 16'hFFFF;
                row_bnd += rr;
            end
            if (r + 1 >= h) begin
                src_row = 0;
                dst_row = 0;
                row_bnd = rr;
            end else begin
                src_row = r + 1;
            end
        end else begin
            src_col = c + 1;
        end
    endfunction

    // caller is at a rising edge; valid stays high for a back-to-back word
    task automatic send_pixel(t_pix_in p);
        if (!quiet && $urandom_range(99) < 20) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= p;
        do @(posedge i_clk); while (o_in_stall);
        downscale_pixel(p);
        pixels_sent++;
    endtask

    task automatic send_random(int n);
        repeat (n) send_pixel(t_pix_in'($urandom));
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [AWBD_IDX_W-1:0] idx, logic [AWBD_CFG_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_SRC_WIDTH:  src_w   = val[12:0];
            REG_SRC_HEIGHT: src_h   = val;
            REG_ROW_RATIO:  row_rat = val[11:0];
            default:        col_rat = val[11:0];
        endcase
        restart_frame();
        @(posedge i_clk);
    endtask

    task automatic setup(int w, int h, int rr, int cr);
        write_reg(REG_SRC_WIDTH, AWBD_CFG_W'(w));
        write_reg(REG_SRC_HEIGHT, AWBD_CFG_W'(h));
        write_reg(REG_ROW_RATIO, AWBD_CFG_W'(rr));
        write_reg(REG_COL_RATIO, AWBD_CFG_W'(cr));
    endtask

    always @(posedge i_clk) begin
        if (stall_hold > 0) begin
            i_out_stall <= 1'b1;
            stall_hold  <= stall_hold - 1;
        end else begin
            i_out_stall <= !quiet && ($urandom_range(99) < 20);
        end
    end

    always @(posedge i_clk) begin
        t_pix_out e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_pixels.size() == 0) begin
                report("output word with nothing expected");
            end else begin
                e = expected_pixels.pop_front();
                if (o_out_data.out_red !== e.out_red)
                    report($sformatf("red %0d exp %0d", o_out_data.out_red, e.out_red));
                if (o_out_data.out_green !== e.out_green)
                    report($sformatf("green %0d exp %0d", o_out_data.out_green, e.out_green));
                if (o_out_data.out_blue !== e.out_blue)
                    report($sformatf("blue %0d exp %0d", o_out_data.out_blue, e.out_blue));
                if (o_out_data.out_alpha !== e.out_alpha)
                    report($sformatf("alpha %0d exp %0d", o_out_data.out_alpha, e.out_alpha));
                if (o_out_data.out_row !== e.out_row)
                    report($sformatf("row %0d exp %0d", o_out_data.out_row, e.out_row));
                if (o_out_data.out_column !== e.out_column)
                    report($sformatf("column %0d exp %0d", o_out_data.out_column,
                                     e.out_column));
                if (o_out_data.frame_end !== e.frame_end)
                    report($sformatf("frame_end %0b exp %0b", o_out_data.frame_end,
                                     e.frame_end));
            end
        end
    end

    task automatic test_extremes();
        setup(4, 2, 256, 256);
        send_pixel('{8'd0, 8'd0, 8'd0, 8'd0});
        send_pixel('{8'd255, 8'd255, 8'd255, 8'd255});
        send_pixel('{8'd255, 8'd0, 8'd255, 8'd1});
        send_pixel('{8'd0, 8'd255, 8'd0, 8'd128});
        drain();
        // two blocks, each mixing transparent and non-transparent members
        setup(4, 2, 512, 512);
        repeat (4) send_pixel('{8'd200, 8'd100, 8'd50, 8'd0});
        send_pixel('{8'd255, 8'd255, 8'd255, 8'd255});
        send_pixel('{8'd10, 8'd20, 8'd30, 8'd0});
        send_pixel('{8'd1, 8'd2, 8'd3, 8'd7});
        send_pixel('{8'd0, 8'd0, 8'd0, 8'd254});
        drain();
    endtask

    task automatic test_degenerate_config();
        // zero sizes and sub-unity ratios: a 1x1 image, every word closes a frame
        setup(0, 0, 0, 0);
        send_random(5);
        drain();
        // oversized width clamps to storage depth
        setup(8191, 65535, 255, 0);
        send_random(6);
        drain();
    endtask

    task automatic test_leftover_and_restart();
        setup(5, 5, 512, 512);
        send_random(7);
        drain();
        // write mid-frame: counters restart
        write_reg(REG_ROW_RATIO, AWBD_CFG_W'(512));
        send_random(25);
        drain();
    endtask

    task automatic test_backpressure();
        setup(8, 8, 256, 256);
        stall_hold = 300;
        send_random(40);
        drain();
    endtask

    task automatic test_random();
        int w, h, rr, cr, n;
        int phase = 0;
        while (pixels_sent < 500) begin
            quiet = (phase == 3);
            if ($urandom_range(5) == 0) begin
                w  = $urandom_range(1, 17);
                h  = $urandom_range(1, 17);
                rr = $urandom_range(1024, 4095);
                cr = $urandom_range(1024, 4095);
            end else begin
                w  = $urandom_range(1, 12);
                h  = $urandom_range(1, 10);
                rr = $urandom_range(256, 1024);
                cr = $urandom_range(256, 1024);
            end
            setup(w, h, rr, cr);
            n = w * h;
            if ($urandom_range(3) == 0) n = $urandom_range(1, n);
            if (n > 120) n = 120;
            send_random(n);
            drain();
            phase++;
        end
        quiet = 1'b0;
        setup(16, 16, 4095, 4095);
        send_random(256);
        drain();
    endtask

    initial begin
        src_w   = RST_SRC_WIDTH;
        src_h   = RST_SRC_HEIGHT;
        row_rat = RST_ROW_RATIO;
        col_rat = RST_COL_RATIO;
        restart_frame();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_degenerate_config();
        test_leftover_and_restart();
        test_backpressure();
        test_random();
        if (errors == 0 && expected_pixels.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

    initial begin
        #4ms;
        $display("tb: FAIL");
        $finish;
    end

endmodule
